>>> rtl/core/lz77pcd_pkg.sv
// shared types and constants for the lz77 prefix-code decoder
// no dependencies
`default_nettype none
package lz77pcd_pkg;

  localparam int HIST_DEPTH = 16384;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int LANES      = 8;
  localparam int LANE_IW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int FILL_W     = $clog2(LANES + 1);

  // distance base per pointer prefix
  localparam logic [13:0] DIST_BASE [5] = '{14'd0, 14'd512, 14'd1536, 14'd3584, 14'd7680};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_RD, ST_WR, ST_END, ST_FLT_FLUSH, ST_FLT_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {TOK_NEED, TOK_LIT, TOK_LEN, TOK_DIST} tok_kind_t;

  typedef struct packed {
    logic load;
    logic put_lit;
    logic put_mem;
    logic take_len;
    logic take_dist;
    logic rd_issue;
    logic flush_end;
    logic flush_lanes;
    logic emit_fault;
  } dp_cmd_t;

  typedef struct packed {
    tok_kind_t tok;
    logic      bad_dist;
    logic      copy_zero;
    logic      finished;
    logic      fault;
    logic      out_free;
    logic      lanes_full;
    logic      lanes_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/lz77pcd_ctrl.sv
// controller state machine: sequences decode, copy and flush of one input beat
// depends on lz77pcd_pkg
`default_nettype none
module lz77pcd_ctrl
  import lz77pcd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         cfg_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctl_state_t state_r, state_nxt;
  logic can_put;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign can_put = !sts.lanes_full || sts.out_free;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        // an input beat goes first, the size write waits while one is offered
        cfg_ready = !in_valid;
        if (in_valid && !sts.finished && !sts.fault) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.finished) begin
          state_nxt = ST_END;
        end else begin
          unique case (sts.tok)
            TOK_NEED: state_nxt = ST_END;
            TOK_LIT:  cmd.put_lit = can_put;
            TOK_LEN:  cmd.take_len = 1'b1;
            TOK_DIST: begin
              cmd.take_dist = 1'b1;
              state_nxt     = sts.bad_dist ? ST_FLT_FLUSH : ST_RD;
            end
            default: state_nxt = ST_END;
          endcase
        end
      end
      ST_RD: begin
        if (sts.finished)       state_nxt = ST_END;
        else if (sts.copy_zero) state_nxt = ST_DECODE;
        else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_WR;
        end
      end
      ST_WR: begin
        if (can_put) begin
          cmd.put_mem = 1'b1;
          state_nxt   = ST_RD;
        end
      end
      ST_END: begin
        if (!sts.lanes_busy || sts.out_free) begin
          cmd.flush_end = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FLT_FLUSH: begin
        if (!sts.lanes_busy || sts.out_free) begin
          cmd.flush_lanes = 1'b1;
          state_nxt       = ST_FLT_EMIT;
        end
      end
      ST_FLT_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_fault = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller checks
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE) else $error("load outside idle");
  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.put_lit || cmd.put_mem) && sts.lanes_full |-> sts.out_free)
    else $error("put while output blocked");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR && $past(state_r) != ST_WR |-> $past(cmd.rd_issue))
    else $error("copy write without read");

endmodule
`default_nettype wire

>>> rtl/core/lz77pcd_dp.sv
// datapath: bit buffer, token decode, history ring, lane packing, output register
// depends on lz77pcd_pkg
`default_nettype none
module lz77pcd_dp
  import lz77pcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_size,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [63:0]      out_data,
  output logic [3:0]       out_count,
  output logic             out_last,
  output logic             out_done,
  output logic             out_status
);

  logic [31:0] orig_r, produced_r, bits_r, bits_nxt;
  logic [5:0]  held_r, held_nxt;
  logic [8:0]  pend_r, copy_cnt_r;
  logic [13:0] dist_r;
  logic [HIST_AW-1:0] wi_r, rd_addr;
  logic        finished_r, fault_r;
  logic [63:0] lane_r;
  logic [FILL_W-1:0] fill_r;
  logic [7:0]  rd_data_r, put_byte;
  logic        put;
  logic [7:0]  hist_mem [HIST_DEPTH];

  logic        ov_r, olast_r, odone_r, ostat_r;
  logic [63:0] odata_r;
  logic [3:0]  ocnt_r;

  // decode signals
  logic [31:0] w, lext, dext;
  logic [2:0]  n;
  logic [2:0]  k;
  logic [5:0]  lpre, ltot, dpre, dtot;
  logic [3:0]  lxb, dxb;
  logic        run;
  logic [8:0]  len_val;
  logic [13:0] dist_val;
  tok_kind_t   tok;
  logic        emit_lanes, out_free, lanes_full;

  // window with oldest bit at bit 31
  assign w = bits_r << (6'd32 - held_r);

  // length code: count ones after the leading one
  always_comb begin
    n   = 3'd0;
    run = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (run && w[30-i]) n = n + 3'd1;
      else run = 1'b0;
    end
  end
  assign lpre    = (n < 3'd6) ? 6'(n) + 6'd2 : 6'd7;
  assign lxb     = 4'(n) + 4'd1;
  assign ltot    = lpre + 6'(lxb);
  assign lext    = (w >> (6'd32 - ltot)) & ((32'd1 << lxb) - 32'd1);
  assign len_val = 9'((32'd1 << lxb) + 32'd1 + lext);

  // distance code: up to four prefix ones
  always_comb begin
    k = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (32'(k) == 32'(i) && w[31-i]) k = k + 3'd1;
    end
  end
  assign dpre     = (k < 3'd4) ? 6'(k) + 6'd1 : 6'd4;
  assign dxb      = 4'd9 + 4'(k);
  assign dtot     = dpre + 6'(dxb);
  assign dext     = (w >> (6'd32 - dtot)) & ((32'd1 << dxb) - 32'd1);
  assign dist_val = DIST_BASE[k] + 14'(dext) + 14'd1;

  // token classification
  always_comb begin
    tok = TOK_NEED;
    if (pend_r == 9'd0) begin
      if (held_r != 6'd0) begin
        if (!w[31]) tok = (held_r >= 6'd9) ? TOK_LIT : TOK_NEED;
        else        tok = (held_r >= ltot) ? TOK_LEN : TOK_NEED;
      end
    end else begin
      tok = (held_r >= dtot) ? TOK_DIST : TOK_NEED;
    end
  end

  assign out_free   = !ov_r || out_ready;
  assign lanes_full = (fill_r == FILL_W'(LANES));
  assign put        = cmd.put_lit || cmd.put_mem;
  assign put_byte   = cmd.put_lit ? w[30:23] : rd_data_r;
  assign rd_addr    = wi_r - HIST_AW'(dist_r);

  always_comb begin
    sts.tok        = tok;
    sts.bad_dist   = {18'd0, dist_val} > produced_r;
    sts.copy_zero  = (copy_cnt_r == 9'd0);
    sts.finished   = finished_r;
    sts.fault      = fault_r;
    sts.out_free   = out_free;
    sts.lanes_full = lanes_full;
    sts.lanes_busy = (fill_r != '0);
  end

  // bit buffer next value
  always_comb begin
    held_nxt = held_r;
    bits_nxt = bits_r;
    if (cmd.load) begin
      held_nxt = held_r + 6'd8;
      bits_nxt = {bits_r[23:0], in_byte};
    end else if (cmd.put_lit || cmd.take_len || cmd.take_dist) begin
      if (cmd.put_lit)       held_nxt = held_r - 6'd9;
      else if (cmd.take_len) held_nxt = held_r - ltot;
      else                   held_nxt = held_r - dtot;
      bits_nxt = bits_r & ((32'd1 << held_nxt) - 32'd1);
    end
    if ((cmd.flush_end && finished_r) || cmd.emit_fault) begin
      held_nxt = 6'd0;
      bits_nxt = 32'd0;
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (put) hist_mem[wi_r] <= put_byte;
    if (cmd.rd_issue) rd_data_r <= hist_mem[rd_addr];
  end

  // decoder control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orig_r     <= 32'd0;
      produced_r <= 32'd0;
      held_r     <= 6'd0;
      bits_r     <= 32'd0;
      pend_r     <= 9'd0;
      copy_cnt_r <= 9'd0;
      wi_r       <= '0;
      finished_r <= 1'b1;
      fault_r    <= 1'b0;
      fill_r     <= '0;
    end else if (cfg_we) begin
      orig_r     <= cfg_size;
      produced_r <= 32'd0;
      held_r     <= 6'd0;
      bits_r     <= 32'd0;
      pend_r     <= 9'd0;
      copy_cnt_r <= 9'd0;
      wi_r       <= '0;
      finished_r <= (cfg_size == 32'd0);
      fault_r    <= 1'b0;
      fill_r     <= '0;
    end else begin
      held_r <= held_nxt;
      bits_r <= bits_nxt;
      if (cmd.take_len) pend_r <= len_val;
      if (cmd.take_dist) begin
        pend_r     <= 9'd0;
        copy_cnt_r <= pend_r;
      end
      if (cmd.put_mem) copy_cnt_r <= copy_cnt_r - 9'd1;
      if (put) begin
        wi_r       <= wi_r + 1'b1;
        produced_r <= produced_r + 32'd1;
        if (produced_r + 32'd1 == orig_r) finished_r <= 1'b1;
        fill_r     <= lanes_full ? FILL_W'(1) : fill_r + 1'b1;
      end
      if (cmd.flush_end || cmd.flush_lanes) fill_r <= '0;
      if (cmd.emit_fault) fault_r <= 1'b1;
    end
  end

  // lane word and distance payload
  always_ff @(posedge clk) begin
    if (cmd.take_dist) dist_r <= dist_val;
    if (put) begin
      if (lanes_full) lane_r <= {56'd0, put_byte};
      else lane_r[8*LANE_IW'(fill_r) +: 8] <= put_byte;
    end
    if (cfg_we || cmd.flush_end || cmd.flush_lanes) lane_r <= 64'd0;
  end

  // output register
  assign emit_lanes = (put && lanes_full) ||
                      ((cmd.flush_end || cmd.flush_lanes) && fill_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_lanes || cmd.emit_fault) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fault) begin
      odata_r <= 64'd0;
      ocnt_r  <= 4'd0;
      olast_r <= 1'b1;
      odone_r <= 1'b0;
      ostat_r <= 1'b1;
    end else if (emit_lanes) begin
      odata_r <= lane_r;
      ocnt_r  <= 4'(fill_r);
      olast_r <= cmd.flush_end;
      odone_r <= cmd.flush_end && finished_r;
      ostat_r <= 1'b0;
    end
  end

  assign out_valid  = ov_r;
  assign out_data   = odata_r;
  assign out_count  = ocnt_r;
  assign out_last   = olast_r;
  assign out_done   = odone_r;
  assign out_status = ostat_r;

  // datapath checks
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    produced_r <= orig_r) else $error("produced past original size");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(LANES)) else $error("lane fill out of range");
  a_empty_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ocnt_r == 4'd0 |-> ostat_r) else $error("empty result without fault");
  a_no_emit_block: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_lanes || cmd.emit_fault) |-> out_free) else $error("result overwritten");

endmodule
`default_nettype wire

>>> rtl/core/lz77_prefix_code_decoder_top.sv
// Decoder for an LZ77 stream with unary-prefixed length and distance codes, fed one
// compressed byte per beat on in_*, giving groups of up to eight bytes on out_*.
// One input beat is taken in idle; decode then runs one code per cycle (a literal,
// a length code or a distance code) while the output does not block a literal; each
// match byte is a registered history read, then a write, and a last read state sees the
// copy is done. A beat ends with a decode that finds too few bits, then the end flush.
// Writing cfg_data restarts decoding with a new original size; a size write waits while
// an input beat is offered. A bad distance gives one result with status set and the
// decoder ignores input until the next config write.
// depends on lz77pcd_pkg, lz77pcd_ctrl, lz77pcd_dp
`default_nettype none
module lz77_prefix_code_decoder_top
  import lz77pcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // out_data[63:0], byte_count[67:64], zero pad
  output logic             out_tlast,  // last_of_run
  output logic [1:0]       out_tuser,  // file_done[0], status[1]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // orig_size
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [63:0] odata;
  logic [3:0]  ocnt;
  logic        odone, ostat;

  lz77pcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cfg_ready(cfg_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lz77pcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_size  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (odata),
    .out_count (ocnt),
    .out_last  (out_tlast),
    .out_done  (odone),
    .out_status(ostat)
  );

  assign out_tdata = {4'd0, ocnt, odata};
  assign out_tuser = {ostat, odone};

endmodule
`default_nettype wire
